>>> hdl/fp83_pkg.sv
`timescale 1ns / 1ps

package fp83_pkg;

   // Field geometry of the packed 8.3 result.
   localparam int NAME_FIELD_CHARS = 8;
   localparam int EXT_FIELD_CHARS  = 3;

   // Default character limits.
   localparam int NAME_CHARS_DEFAULT = 8;
   localparam int EXT_CHARS_DEFAULT  = 3;

   // Characters with a meaning of their own.
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_LEGAL         = 3'd0,
      ST_ILLEGAL_CHAR  = 3'd1,
      ST_NAME_TOO_LONG = 3'd2,
      ST_EXT_TOO_LONG  = 3'd3,
      ST_EMPTY_OR_DOT  = 3'd4
   } status_type;

   // One registered item handed from the input stage to the parser.
   typedef struct packed {
      logic       valid;
      logic [7:0] ch;
      logic       start_new;
   } step_type;

endpackage

>>> hdl/fp83_if.sv
`timescale 1ns / 1ps

// Character channel: one item per character of the file name.
interface fp83_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       start_new;

   modport source (output valid, ch, start_new, input ready);
   modport sink (input valid, ch, start_new, output ready);
endinterface

// Result channel: one item per checked file name.
interface fp83_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] name_field;
   logic [23:0] ext_field;
   logic [3:0]  name_len;
   logic [1:0]  ext_len;

   modport source (output valid, status, name_field, ext_field, name_len, ext_len,
                   input ready);
   modport sink (input valid, status, name_field, ext_field, name_len, ext_len,
                 output ready);
endinterface

>>> hdl/filename_83_validate_pack_unit.sv
`timescale 1ns / 1ps
// The item that ends a name passes the input register, then sets the result register.
// Throughput: one character item per cycle, a single compare-and-insert between the input
// register and the result register; items stall while an untaken result is held.
// Reset: synchronous, active high; the parser returns to idle with space-filled fields
// and both channels empty.

module filename_83_validate_pack_unit
   import fp83_pkg::*;
#(
   parameter int NAME_CHARS = NAME_CHARS_DEFAULT,
   parameter int EXT_CHARS  = EXT_CHARS_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   fp83_req_if.sink      req_port,
   fp83_rsp_if.source    rsp_port
);

   step_type step;
   logic     advance;

   // Input register for one character item.
   fp83_input_stage u_input_stage (
      .clock   (clock),
      .reset   (reset),
      .req     (req_port),
      .advance (advance),
      .step    (step)
   );

   // Parser state, one step per item, and the result register.
   fp83_parser #(
      .NAME_CHARS (NAME_CHARS),
      .EXT_CHARS  (EXT_CHARS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .advance (advance),
      .rsp     (rsp_port)
   );

`ifndef NO_ASSERTIONS
   // A new result only follows a character that was processed.
   a_result_from_step : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_port.valid) |-> $past(advance))
      else $error("result appeared without a processed item");

   // A legal name always has at least one name character.
   a_legal_not_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.status == ST_LEGAL) |-> (rsp_port.name_len != 4'd0))
      else $error("legal result with an empty name");

   // An extension can only exist after a non-empty name.
   a_ext_needs_name : assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.ext_len != 2'd0) |-> (rsp_port.name_len != 4'd0))
      else $error("extension reported without a name");

   // The name count never exceeds the width of the packed name field.
   a_len_range : assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (rsp_port.name_len <= 4'd8))
      else $error("name length beyond field width");
`endif

endmodule

>>> hdl/fp83_input_stage.sv
`timescale 1ns / 1ps

module fp83_input_stage
   import fp83_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   fp83_req_if.sink      req,
   input  logic          advance,
   output step_type      step
);

   logic       valid_ff, valid_in;
   logic [7:0] ch_ff;
   logic       start_ff;
   logic       take;

   // The register is free when empty or when its item moves on this cycle.
   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   // Valid bit is control state; the character itself needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         ch_ff    <= req.ch;
         start_ff <= req.start_new;
      end
   end

   assign step.valid     = valid_ff;
   assign step.ch        = ch_ff;
   assign step.start_new = start_ff;

endmodule

>>> hdl/fp83_parser.sv
`timescale 1ns / 1ps

module fp83_parser
   import fp83_pkg::*;
#(
   parameter int NAME_CHARS = NAME_CHARS_DEFAULT,
   parameter int EXT_CHARS  = EXT_CHARS_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  step_type      step,
   output logic          advance,
   fp83_rsp_if.source    rsp
);

   // Limits are capped at the widths of the packed fields.
   localparam int NameLim = (NAME_CHARS > NAME_FIELD_CHARS) ? NAME_FIELD_CHARS : NAME_CHARS;
   localparam int ExtLim  = (EXT_CHARS > EXT_FIELD_CHARS) ? EXT_FIELD_CHARS : EXT_CHARS;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_NAME = 2'd1,
      PH_EXT  = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in, phase_cur;
   logic [3:0]  name_count_ff, name_count_in, name_count_cur;
   logic [1:0]  ext_count_ff, ext_count_in, ext_count_cur;
   logic [63:0] name_shift_ff, name_shift_in, name_shift_cur;
   logic [23:0] ext_shift_ff, ext_shift_in, ext_shift_cur;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic [63:0] name_field_ff;
   logic [23:0] ext_field_ff;
   logic [3:0]  name_len_ff;
   logic [1:0]  ext_len_ff;

   logic        emit;
   logic        is_digit, is_upper, is_lower, is_dot, is_nul, is_legal;

   // An item is processed when the result register can take what it may emit.
   assign advance = step.valid && (!rsp_valid_ff || rsp.ready);

   // Character classes.
   always_comb begin
      is_digit = (step.ch >= 8'h30) && (step.ch <= 8'h39);
      is_upper = (step.ch >= 8'h41) && (step.ch <= 8'h5A);
      is_lower = (step.ch >= 8'h61) && (step.ch <= 8'h7A);
      is_dot   = (step.ch == CHAR_DOT);
      is_nul   = (step.ch == CHAR_NUL);
      is_legal = is_digit || is_upper || is_lower || is_dot || is_nul;
   end

   // A start flag clears the parser before the character is looked at.
   always_comb begin
      if (step.start_new) begin
         phase_cur      = PH_NAME;
         name_count_cur = '0;
         ext_count_cur  = '0;
         name_shift_cur = {NAME_FIELD_CHARS{CHAR_SPACE}};
         ext_shift_cur  = {EXT_FIELD_CHARS{CHAR_SPACE}};
      end else begin
         phase_cur      = phase_ff;
         name_count_cur = name_count_ff;
         ext_count_cur  = ext_count_ff;
         name_shift_cur = name_shift_ff;
         ext_shift_cur  = ext_shift_ff;
      end
   end

   // One parsing step: classify the character, update the fields, decide on a result.
   always_comb begin
      phase_in      = phase_cur;
      name_count_in = name_count_cur;
      ext_count_in  = ext_count_cur;
      name_shift_in = name_shift_cur;
      ext_shift_in  = ext_shift_cur;
      emit          = 1'b0;
      status_in     = ST_LEGAL;

      unique case (phase_cur)
         PH_NAME: begin
            if (!is_legal) begin
               emit      = 1'b1;
               status_in = ST_ILLEGAL_CHAR;
            end else if (is_nul) begin
               emit      = 1'b1;
               status_in = (name_count_cur == '0) ? ST_EMPTY_OR_DOT : ST_LEGAL;
            end else if (is_dot) begin
               if (name_count_cur == '0) begin
                  emit      = 1'b1;
                  status_in = ST_EMPTY_OR_DOT;
               end else begin
                  phase_in = PH_EXT;
               end
            end else if (name_count_cur >= 4'(NameLim)) begin
               emit      = 1'b1;
               status_in = ST_NAME_TOO_LONG;
            end else begin
               for (int i = 0; i < NAME_FIELD_CHARS; i++) begin
                  if (name_count_cur == 4'(i)) begin
                     name_shift_in[8*(NAME_FIELD_CHARS-1-i) +: 8] = step.ch;
                  end
               end
               name_count_in = name_count_cur + 4'd1;
            end
         end
         PH_EXT: begin
            if (!is_legal) begin
               emit      = 1'b1;
               status_in = ST_ILLEGAL_CHAR;
            end else if (is_nul) begin
               emit      = 1'b1;
               status_in = ST_LEGAL;
            end else if (is_dot) begin
               emit      = 1'b1;
               status_in = ST_EMPTY_OR_DOT;
            end else if (ext_count_cur >= 2'(ExtLim)) begin
               emit      = 1'b1;
               status_in = ST_EXT_TOO_LONG;
            end else begin
               for (int i = 0; i < EXT_FIELD_CHARS; i++) begin
                  if (ext_count_cur == 2'(i)) begin
                     ext_shift_in[8*(EXT_FIELD_CHARS-1-i) +: 8] = step.ch;
                  end
               end
               ext_count_in = ext_count_cur + 2'd1;
            end
         end
         default: begin
            // Idle: characters are ignored until the next start.
         end
      endcase

      if (emit) begin
         phase_in = PH_IDLE;
      end
   end

   // Result handshake: loaded on an emitting step, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Parser state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         name_count_ff <= '0;
         ext_count_ff  <= '0;
         name_shift_ff <= {NAME_FIELD_CHARS{CHAR_SPACE}};
         ext_shift_ff  <= {EXT_FIELD_CHARS{CHAR_SPACE}};
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff      <= phase_in;
            name_count_ff <= name_count_in;
            ext_count_ff  <= ext_count_in;
            name_shift_ff <= name_shift_in;
            ext_shift_ff  <= ext_shift_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && emit) begin
         status_ff     <= status_in;
         name_field_ff <= name_shift_cur;
         ext_field_ff  <= ext_shift_cur;
         name_len_ff   <= name_count_cur;
         ext_len_ff    <= ext_count_cur;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = status_ff;
   assign rsp.name_field = name_field_ff;
   assign rsp.ext_field  = ext_field_ff;
   assign rsp.name_len   = name_len_ff;
   assign rsp.ext_len    = ext_len_ff;

endmodule
